// File: rtl/core/mmlp_pkg.sv
`default_nettype none

package mmlp_pkg;

	// result kinds
	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// input command codes
	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	// characters that steer the parse
	localparam logic [7:0] CH_DASH    = 8'h2d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	// number of permission characters
	localparam logic [2:0] PERM_CHARS = 3'd4;

	typedef struct packed {
		logic       command;
		logic [7:0] text_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_byte;
		logic [63:0] region_start;
		logic [63:0] region_end;
		logic [31:0] perm_chars;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/mmlp_stream_if.sv
`default_nettype none

// input channel: one text byte or an end-of-stream command per item
interface mmlp_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] text_byte;

	modport source(output valid, command, text_byte, input ready);
	modport sink(input valid, command, text_byte, output ready);
endinterface

// output channel: name byte, mapping record or end of list
interface mmlp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_byte;
	logic [63:0] region_start;
	logic [63:0] region_end;
	logic [31:0] perm_chars;

	modport source(output valid, kind, name_byte, region_start, region_end, perm_chars,
		input ready);
	modport sink(input valid, kind, name_byte, region_start, region_end, perm_chars,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/memory_map_line_parser_core.sv
// path: an accepted item is held in the input register, and its result item, if
//   any, is then loaded into the result register unless map_out is stalled
// throughput: one item per cycle while map_out is ready, set by the single
//   parse step between the input register and the result register
// reset: arst_n clears the line state to the start address field with empty
//   accumulators, and empties the input and result registers
`default_nettype none

module memory_map_line_parser_core #(
	parameter int ADDR_BITS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mmlp_in_if.sink   text_in,
	mmlp_out_if.source map_out
);
	import mmlp_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	// the held item moves on when the result register is free or draining
	assign advance = !out_valid_q || map_out.ready;

	// input register
	mmlp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.advance  (advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	// line state and decode
	mmlp_parser #(
		.ADDR_BITS (ADDR_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (valid_s1 && advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign map_out.valid        = out_valid_q;
	assign map_out.kind         = out_q.kind;
	assign map_out.name_byte    = out_q.name_byte;
	assign map_out.region_start = out_q.region_start;
	assign map_out.region_end   = out_q.region_end;
	assign map_out.perm_chars   = out_q.perm_chars;

endmodule

`default_nettype wire

// File: rtl/core/mmlp_in_reg.sv
`default_nettype none

module mmlp_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mmlp_in_if.sink             text_in,
	input  wire logic           advance,
	output mmlp_pkg::item_t     item_s1,
	output logic                valid_s1
);
	import mmlp_pkg::*;

	// take a new item whenever the register is empty or the held one moves on this cycle
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			item_s1.command   <= text_in.command;
			item_s1.text_byte <= text_in.text_byte;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mmlp_parser.sv
`default_nettype none

module mmlp_parser #(
	parameter int ADDR_BITS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire mmlp_pkg::item_t  item,
	output logic                  res_valid,
	output mmlp_pkg::result_t     res
);
	import mmlp_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_END,
		PH_PERM,
		PH_OFFSET,
		PH_DEV,
		PH_INODE,
		PH_PAD,
		PH_NAME
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [ADDR_BITS-1:0] start_q, start_d;
	logic [ADDR_BITS-1:0] end_q, end_d;
	logic [31:0]          perm_q, perm_d;
	logic [2:0]           count_q, count_d;
	logic [7:0]           c;
	logic [3:0]           digit;
	logic                 clear;

	// hex digit value, anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [7:0] v;
		v = 8'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			v = ch - CH_ZERO;
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
			v = ch - CH_LOWER_A + HEX_TEN;
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
			v = ch - CH_UPPER_A + HEX_TEN;
		end
		return v[3:0];
	endfunction

	assign c     = item.text_byte;
	assign digit = hex_value(c);

	// next line state and the result of this item
	always_comb begin
		phase_d   = phase_q;
		start_d   = start_q;
		end_d     = end_q;
		perm_d    = perm_q;
		count_d   = count_q;
		clear     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		if (item.command == CMD_EOS) begin
			res_valid = 1'b1;
			res.kind  = KIND_END;
			clear     = 1'b1;
		end else begin
			case (phase_q)
				PH_START: begin
					if (c == CH_DASH) phase_d = PH_END;
					else start_d = {start_q[ADDR_BITS-5:0], digit};
				end
				PH_END: begin
					if (c == CH_SPACE) phase_d = PH_PERM;
					else end_d = {end_q[ADDR_BITS-5:0], digit};
				end
				PH_PERM: begin
					if (count_q < PERM_CHARS) begin
						perm_d  = {perm_q[23:0], c};
						count_d = count_q + 3'd1;
					end else begin
						phase_d = PH_OFFSET;
					end
				end
				PH_OFFSET: begin
					if (c == CH_SPACE) phase_d = PH_DEV;
				end
				PH_DEV: begin
					if (c == CH_SPACE) phase_d = PH_INODE;
				end
				PH_INODE: begin
					if (c == CH_NEWLINE) begin
						res_valid = 1'b1;
						res.kind  = KIND_RECORD;
						clear     = 1'b1;
					end else if (c == CH_SPACE) begin
						phase_d = PH_PAD;
					end
				end
				PH_PAD: begin
					if (c == CH_NEWLINE) begin
						res_valid = 1'b1;
						res.kind  = KIND_RECORD;
						clear     = 1'b1;
					end else if (c != CH_SPACE) begin
						phase_d       = PH_NAME;
						res_valid     = 1'b1;
						res.kind      = KIND_NAME;
						res.name_byte = c;
					end
				end
				PH_NAME: begin
					res_valid = 1'b1;
					if (c == CH_NEWLINE) begin
						res.kind = KIND_RECORD;
						clear    = 1'b1;
					end else begin
						res.kind      = KIND_NAME;
						res.name_byte = c;
					end
				end
				default: begin
					phase_d = PH_START;
				end
			endcase
			// a record carries the line as it stood before this byte
			if (res.kind == KIND_RECORD && res_valid) begin
				res.region_start = 64'(start_q);
				res.region_end   = 64'(end_q);
				res.perm_chars   = perm_q;
			end
		end
		if (clear) begin
			phase_d = PH_START;
			start_d = '0;
			end_d   = '0;
			perm_d  = '0;
			count_d = '0;
		end
	end

	// line state, updated once per parsed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			start_q <= '0;
			end_q   <= '0;
			perm_q  <= '0;
			count_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			start_q <= start_d;
			end_q   <= end_d;
			perm_q  <= perm_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire
